// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define COT_ASSERT(lbl, c, r, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define COT_ASSERT_ALWAYS(lbl, c, prop, msg) \
  lbl: assert property (@(posedge c) prop) else $error(msg);

`endif

// ----- hw/rtl/cot_pkg.sv -----
package cot_pkg;

  // Object queue sizing.
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  // Queue between the front and the back end (power of two depth).
  localparam int MIDQ_DEPTH = 2;
  localparam int MIDQ_PTR_W = 1;
  localparam int MIDQ_CNT_W = 2;

  // Result queue at the output (power of two depth).
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  // Configuration register map.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEAD = 2'd1;

  localparam logic [31:0] RESET_CAMERA_OFFSET = 32'd3000;
  localparam logic [15:0] RESET_IDLE_LEAD = 16'd500;

  localparam int PENDING_W = 5;

  typedef struct packed {
    logic [31:0] camera_offset;
    logic [15:0] idle_lead;
  } cfg_t;

  // One classified tick, as handed from the front to the back end.
  typedef struct packed {
    logic [31:0] belt_position;
    logic [31:0] obj_start;
    logic [31:0] obj_stop;
    logic        at_target;
    logic        started;
    logic        finished;
    logic        in_obj;
  } tick_t;

  // One stored object: leading and trailing edge positions.
  typedef struct packed {
    logic [31:0] start_pos;
    logic [31:0] stop_pos;
  } obj_t;

  typedef struct packed {
    logic [31:0]          stop_target;
    logic                 acquire_now;
    logic                 object_started;
    logic                 object_finished;
    logic                 inside_object;
    logic [PENDING_W-1:0] pending_count;
    logic                 queue_overflow;
  } result_t;

  // Point midway from a leading to a trailing edge, correct across an encoder wrap.
  function automatic logic [31:0] midpoint(input logic [31:0] b, input logic [31:0] e);
    logic [31:0] span;
    span = e - b;
    return b + {1'b0, span[31:1]};
  endfunction

endpackage

// ----- hw/rtl/cot_front.sv -----
module cot_front
  import cot_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_belt_position,
  input  logic [31:0] in_latched_begin,
  input  logic [31:0] in_latched_end,
  input  logic        in_at_target,
  output logic        tick_valid,
  input  logic        tick_ready,
  output tick_t       tick
);

  logic        primed_r, primed_nxt;
  logic        in_object_r, in_object_nxt;
  logic [31:0] prev_begin_r, prev_begin_nxt;
  logic [31:0] prev_end_r, prev_end_nxt;

  tick_t                 midq_r [MIDQ_DEPTH];
  logic [MIDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [MIDQ_CNT_W-1:0] cnt_r;

  tick_t rec;
  logic  accept, take;

  assign full   = (cnt_r == MIDQ_CNT_W'(MIDQ_DEPTH));
  assign accept = push && !full;
  assign take   = tick_valid && tick_ready;

  // Edge detection on the latched photocell positions.
  always_comb begin
    primed_nxt     = primed_r;
    in_object_nxt  = in_object_r;
    prev_begin_nxt = prev_begin_r;
    prev_end_nxt   = prev_end_r;
    rec.belt_position = in_belt_position;
    rec.obj_start     = prev_begin_r;
    rec.obj_stop      = in_latched_end;
    rec.at_target     = in_at_target;
    rec.started       = 1'b0;
    rec.finished      = 1'b0;
    priority if (!primed_r) begin
      prev_begin_nxt = in_latched_begin;
      prev_end_nxt   = in_latched_end;
      primed_nxt     = 1'b1;
    end else if (!in_object_r) begin
      if (in_latched_begin != prev_begin_r) begin
        prev_begin_nxt = in_latched_begin;
        in_object_nxt  = 1'b1;
        rec.started    = 1'b1;
      end
    end else begin
      if (in_latched_end != prev_end_r) begin
        prev_end_nxt  = in_latched_end;
        in_object_nxt = 1'b0;
        rec.finished  = 1'b1;
      end
    end
    rec.in_obj = in_object_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r     <= 1'b0;
      in_object_r  <= 1'b0;
      prev_begin_r <= '0;
      prev_end_r   <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (accept) begin
        primed_r     <= primed_nxt;
        in_object_r  <= in_object_nxt;
        prev_begin_r <= prev_begin_nxt;
        prev_end_r   <= prev_end_nxt;
        wr_ptr_r     <= wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + MIDQ_CNT_W'(accept) - MIDQ_CNT_W'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      midq_r[wr_ptr_r] <= rec;
    end
  end

  assign tick_valid = (cnt_r != '0);
  assign tick       = midq_r[rd_ptr_r];

endmodule

// ----- hw/rtl/cot_back.sv -----
module cot_back
  import cot_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    tick_valid,
  output logic    tick_ready,
  input  tick_t   tick,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  // Object queue.
  obj_t             mem [QUEUE_DEPTH];
  obj_t             rd_data_r;
  logic [PTR_W-1:0] head_r, head_nxt, head_inc, wr_slot;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0] slot_sum;
  obj_t             wdata, entry;
  logic             q_full, wr_en, have_obj, acquire, fire;

  // Target stage.
  logic                 b_valid_r;
  logic [31:0]          b_base_r;
  logic                 b_use_obj_r;
  logic                 b_acquire_r, b_started_r, b_finished_r, b_inside_r, b_overflow_r;
  logic [PENDING_W-1:0] b_pending_r;
  result_t              b_result;

  // Result queue.
  result_t               outq_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] owr_ptr_r, ord_ptr_r;
  logic [OUTQ_CNT_W-1:0] ocnt_r, occ;
  logic                  opop;

  // Credit check: the target stage never has to wait on the result queue.
  assign occ        = ocnt_r + OUTQ_CNT_W'(b_valid_r);
  assign tick_ready = (occ < OUTQ_CNT_W'(OUTQ_DEPTH));
  assign fire       = tick_valid && tick_ready;

  always_comb begin
    q_full   = (fill_r == FILL_W'(QUEUE_DEPTH));
    wr_en    = fire && tick.finished && !q_full;
    slot_sum = SUM_W'(head_r) + SUM_W'(fill_r);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      wr_slot = PTR_W'(slot_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      wr_slot = PTR_W'(slot_sum);
    end
    wdata.start_pos = tick.obj_start;
    wdata.stop_pos  = tick.obj_stop;
    have_obj = (fill_r != '0) || (tick.finished && !q_full);
    entry    = (fill_r == '0) ? wdata : rd_data_r;
    acquire  = have_obj && tick.at_target;
    head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (fire) begin
      if (acquire) begin
        head_nxt = head_inc;
      end
      fill_nxt = fill_r + FILL_W'(wr_en) - FILL_W'(acquire);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wdata;
    end
    // Keeps the entry at the head ready; a write to that slot is forwarded.
    if (wr_en && (wr_slot == head_nxt)) begin
      rd_data_r <= wdata;
    end else begin
      rd_data_r <= mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      fill_r    <= '0;
      b_valid_r <= 1'b0;
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      b_valid_r <= fire;
      if (b_valid_r) begin
        owr_ptr_r <= owr_ptr_r + 1'b1;
      end
      if (opop) begin
        ord_ptr_r <= ord_ptr_r + 1'b1;
      end
      ocnt_r <= ocnt_r + OUTQ_CNT_W'(b_valid_r) - OUTQ_CNT_W'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_base_r     <= have_obj ? midpoint(entry.start_pos, entry.stop_pos)
                               : tick.belt_position;
      b_use_obj_r  <= have_obj;
      b_acquire_r  <= acquire;
      b_started_r  <= tick.started;
      b_finished_r <= tick.finished;
      b_inside_r   <= tick.in_obj;
      b_overflow_r <= tick.finished && q_full;
      b_pending_r  <= PENDING_W'(fill_nxt);
    end
  end

  always_comb begin
    b_result.stop_target     = b_base_r + (b_use_obj_r ? cfg.camera_offset
                                                       : {16'd0, cfg.idle_lead});
    b_result.acquire_now     = b_acquire_r;
    b_result.object_started  = b_started_r;
    b_result.object_finished = b_finished_r;
    b_result.inside_object   = b_inside_r;
    b_result.pending_count   = b_pending_r;
    b_result.queue_overflow  = b_overflow_r;
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      outq_r[owr_ptr_r] <= b_result;
    end
  end

  assign empty  = (ocnt_r == '0);
  assign opop   = pop && !empty;
  assign result = outq_r[ord_ptr_r];

endmodule

// ----- hw/rtl/conveyor_object_tracker_core.sv -----
// Conveyor object tracker. Each input beat is one poll tick: belt encoder position,
// the photocell's latched leading and trailing edge positions and the in-position flag.
// Every input beat yields exactly one result beat with the stop target and status flags.
// The input side is a queue: a beat is taken when push is high and full is low.
// The result side is a queue too: the oldest result is shown while empty is low and is
// taken when pop is high. Configuration writes (camera offset at index 0, idle lead at
// index 1, other indexes ignored) complete whenever cfg_valid is high; cfg_ready is
// always high, and writes belong in idle periods.
// One beat per cycle is sustained while the receiver pops results: the front
// stage classifies a tick in its accepting cycle, and the back end updates the
// object queue and reads its head entry in the cycle it takes the tick, then
// adds the offset in the next.
// Synchronous reset empties all queues, clears the tracking state and restores the
// register defaults; the object store needs no clearing pass since only written
// entries are ever read. When the receiver stalls, the four-entry result queue fills,
// the two-entry queue after the front stage backs up and full rises.
module conveyor_object_tracker_core
  import cot_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Tick input
  input  logic                 push,
  output logic                 full,
  input  logic [31:0]          in_belt_position,
  input  logic [31:0]          in_latched_begin,
  input  logic [31:0]          in_latched_end,
  input  logic                 in_at_target,
  // Results
  output logic                 empty,
  input  logic                 pop,
  output logic [31:0]          out_stop_target,
  output logic                 out_acquire_now,
  output logic                 out_object_started,
  output logic                 out_object_finished,
  output logic                 out_inside_object,
  output logic [PENDING_W-1:0] out_pending_count,
  output logic                 out_queue_overflow,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t    cfg_r;
  tick_t   tick;
  logic    tick_valid, tick_ready;
  result_t result;

  // The register file takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.camera_offset <= RESET_CAMERA_OFFSET;
      cfg_r.idle_lead     <= RESET_IDLE_LEAD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CAMERA_OFFSET: cfg_r.camera_offset <= cfg_data;
        CFG_IDLE_LEAD:     cfg_r.idle_lead     <= cfg_data[15:0];
        default: begin
          // Unmapped index: the write has no effect.
        end
      endcase
    end
  end

  // The front stage tracks the edges and hands classified ticks on through its queue.
  cot_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_belt_position (in_belt_position),
    .in_latched_begin (in_latched_begin),
    .in_latched_end   (in_latched_end),
    .in_at_target     (in_at_target),
    .tick_valid       (tick_valid),
    .tick_ready       (tick_ready),
    .tick             (tick)
  );

  // The back end owns the object queue, forms the stop target and buffers results.
  cot_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .tick_valid (tick_valid),
    .tick_ready (tick_ready),
    .tick       (tick),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  assign out_stop_target     = result.stop_target;
  assign out_acquire_now     = result.acquire_now;
  assign out_object_started  = result.object_started;
  assign out_object_finished = result.object_finished;
  assign out_inside_object   = result.inside_object;
  assign out_pending_count   = result.pending_count;
  assign out_queue_overflow  = result.queue_overflow;

endmodule

// ----- hw/rtl/cot_checker.sv -----
`include "assert_macros.svh"

module cot_checker
  import cot_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic [31:0]          out_stop_target,
  input logic                 out_object_started,
  input logic                 out_object_finished,
  input logic                 out_inside_object,
  input logic                 out_queue_overflow
);

  `COT_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (empty && !full), "reset left a beat queued")

  `COT_ASSERT(a_edges_exclusive, clk, rst_n, !empty |-> !(out_object_started && out_object_finished), "start and finish in one tick")

  `COT_ASSERT(a_inside_follows_edge, clk, rst_n, (!empty && (out_object_started || out_object_finished)) |-> (out_inside_object == out_object_started), "inside flag disagrees with edge")

  `COT_ASSERT(a_overflow_on_finish, clk, rst_n, (!empty && out_queue_overflow) |-> out_object_finished, "overflow without a finished object")

  `COT_ASSERT(a_result_holds, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_stop_target)), "waiting result changed")

endmodule

bind conveyor_object_tracker_core cot_checker u_cot_checker (.*);
